/* hw/rtl/rvx_pkg.sv */
// Shared types and constants of the RV32I executor.
`timescale 1ns / 1ps
package rvx_pkg;

   // Request operation codes
   localparam logic [1:0] OP_WRITE_WORD = 2'd0;
   localparam logic [1:0] OP_EXECUTE    = 2'd1;
   localparam logic [1:0] OP_READ_REG   = 2'd2;

   // Run status codes
   localparam logic [1:0] ST_RUNNING = 2'd0;
   localparam logic [1:0] ST_ECALL   = 2'd1;
   localparam logic [1:0] ST_PC_OUT  = 2'd2;

   // Major opcodes
   localparam logic [6:0] OPC_LUI    = 7'h37;
   localparam logic [6:0] OPC_AUIPC  = 7'h17;
   localparam logic [6:0] OPC_JAL    = 7'h6F;
   localparam logic [6:0] OPC_JALR   = 7'h67;
   localparam logic [6:0] OPC_BRANCH = 7'h63;
   localparam logic [6:0] OPC_LOAD   = 7'h03;
   localparam logic [6:0] OPC_STORE  = 7'h23;
   localparam logic [6:0] OPC_OPIMM  = 7'h13;
   localparam logic [6:0] OPC_OP     = 7'h33;
   localparam logic [31:0] INST_ECALL = 32'h0000_0073;

   localparam logic [4:0] REG_A0 = 5'd10;

   // funct3 codes
   localparam logic [2:0] F3_ADD  = 3'd0;
   localparam logic [2:0] F3_SLL  = 3'd1;
   localparam logic [2:0] F3_SLT  = 3'd2;
   localparam logic [2:0] F3_SLTU = 3'd3;
   localparam logic [2:0] F3_XOR  = 3'd4;
   localparam logic [2:0] F3_SR   = 3'd5;
   localparam logic [2:0] F3_OR   = 3'd6;
   localparam logic [2:0] F3_AND  = 3'd7;

   localparam logic [2:0] F3_BEQ  = 3'd0;
   localparam logic [2:0] F3_BNE  = 3'd1;
   localparam logic [2:0] F3_BLT  = 3'd4;
   localparam logic [2:0] F3_BGE  = 3'd5;
   localparam logic [2:0] F3_BLTU = 3'd6;
   localparam logic [2:0] F3_BGEU = 3'd7;

   localparam logic [2:0] F3_LB  = 3'd0;
   localparam logic [2:0] F3_LH  = 3'd1;
   localparam logic [2:0] F3_LW  = 3'd2;
   localparam logic [2:0] F3_LBU = 3'd4;
   localparam logic [2:0] F3_LHU = 3'd5;

   typedef struct packed {
      logic [1:0]  op;
      logic [13:0] word_address;
      logic [31:0] write_data;
      logic [4:0]  reg_index;
   } req_type;

   typedef struct packed {
      logic [31:0]        reg_value;
      logic signed [31:0] return_value;
      logic [31:0]        current_pc;
      logic [1:0]         halt_status;
   } rsp_type;

   typedef struct packed {
      logic       rd_en;
      logic       wr_en;
      logic [3:0] wr_mask;
   } mem_ctl_type;

   typedef struct packed {
      logic rd_en;
      logic wr_en;
   } rf_ctl_type;

endpackage

/* hw/rtl/rvx_mem.sv */
// Byte-addressed data memory: four byte lanes, unaligned access, clearing pass.
`timescale 1ns / 1ps
module rvx_mem #(
   parameter int ADDR_BITS = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  rvx_pkg::mem_ctl_type  ctl,
   input  logic [ADDR_BITS-1:0]  addr,
   input  logic [31:0]           wr_data,
   output logic [31:0]           rd_data,
   output logic                  busy
);
   localparam int ROW_BITS = ADDR_BITS - 2;
   localparam int ROWS     = 1 << ROW_BITS;

   logic [ROW_BITS-1:0] clr_row_ff;
   logic                clr_on_ff;
   logic [1:0]          off_ff;
   logic [7:0]          lane_q [4];

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_on_ff  <= 1'b1;
         clr_row_ff <= '0;
      end else if (clr_on_ff) begin
         clr_row_ff <= clr_row_ff + ROW_BITS'(1);
         if (&clr_row_ff) clr_on_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.rd_en) off_ff <= addr[1:0];
   end

   for (genvar i = 0; i < 4; i++) begin : g_lane
      logic [1:0]           k;
      logic [ADDR_BITS-1:0] baddr;
      logic [ROW_BITS-1:0]  row;
      logic [7:0]           mem_q [ROWS];
      logic [7:0]           q_ff;

      // byte k of the access lands in this lane
      assign k     = 2'(i) - addr[1:0];
      assign baddr = addr + ADDR_BITS'(k);
      assign row   = baddr[ADDR_BITS-1:2];

      always_ff @(posedge clock) begin
         if (clr_on_ff) begin
            mem_q[clr_row_ff] <= 8'h00;
         end else if (ctl.wr_en && ctl.wr_mask[k]) begin
            mem_q[row] <= wr_data[8*k +: 8];
         end
         if (ctl.rd_en) q_ff <= mem_q[row];
      end

      assign lane_q[i] = q_ff;
   end

   always_comb begin
      for (int k = 0; k < 4; k++) begin
         rd_data[8*k +: 8] = lane_q[2'(k) + off_ff];
      end
   end

   assign busy = clr_on_ff;

endmodule

/* hw/rtl/rvx_regfile.sv */
// Register file: 32 x 32 bits, two registered read ports, valid bits for reset.
`timescale 1ns / 1ps
module rvx_regfile (
   input  logic                 clock,
   input  logic                 reset,
   input  rvx_pkg::rf_ctl_type  ctl,
   input  logic [4:0]           addr_a,
   input  logic [4:0]           addr_b,
   input  logic [4:0]           waddr,
   input  logic [31:0]          wdata,
   output logic [31:0]          rd_a,
   output logic [31:0]          rd_b
);
   logic [31:0] mem_q [32];
   logic [31:0] valid_ff;
   logic [31:0] qa_ff;
   logic [31:0] qb_ff;
   logic        va_ff;
   logic        vb_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         va_ff    <= 1'b0;
         vb_ff    <= 1'b0;
      end else begin
         if (ctl.wr_en) valid_ff[waddr] <= 1'b1;
         if (ctl.rd_en) begin
            va_ff <= valid_ff[addr_a];
            vb_ff <= valid_ff[addr_b];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.wr_en) mem_q[waddr] <= wdata;
      if (ctl.rd_en) begin
         qa_ff <= mem_q[addr_a];
         qb_ff <= mem_q[addr_b];
      end
   end

   assign rd_a = va_ff ? qa_ff : 32'h0;
   assign rd_b = vb_ff ? qb_ff : 32'h0;

endmodule

/* hw/rtl/rvx_alu.sv */
// Integer ALU and branch compare.
`timescale 1ns / 1ps
module rvx_alu (
   input  logic [2:0]  f3,
   input  logic [6:0]  f7,
   input  logic        reg_form,
   input  logic [31:0] a,
   input  logic [31:0] b,
   output logic [31:0] result,
   output logic        take
);
   logic lt_s;
   logic lt_u;

   assign lt_s = $signed(a) < $signed(b);
   assign lt_u = a < b;

   always_comb begin
      case (f3)
         rvx_pkg::F3_ADD:  result = (reg_form && f7 != 7'h0) ? a - b : a + b;
         rvx_pkg::F3_SLL:  result = a << b[4:0];
         rvx_pkg::F3_SLT:  result = {31'h0, lt_s};
         rvx_pkg::F3_SLTU: result = {31'h0, lt_u};
         rvx_pkg::F3_XOR:  result = a ^ b;
         rvx_pkg::F3_SR:   result = (f7 == 7'h0) ? a >> b[4:0]
                                                 : 32'($signed(a) >>> b[4:0]);
         rvx_pkg::F3_OR:   result = a | b;
         default:          result = a & b;
      endcase
   end

   always_comb begin
      case (f3)
         rvx_pkg::F3_BEQ:  take = a == b;
         rvx_pkg::F3_BNE:  take = a != b;
         rvx_pkg::F3_BLT:  take = lt_s;
         rvx_pkg::F3_BGE:  take = !lt_s;
         rvx_pkg::F3_BLTU: take = lt_u;
         rvx_pkg::F3_BGEU: take = !lt_u;
         default:          take = 1'b0;
      endcase
   end

endmodule

/* hw/rtl/rv32i_instruction_executor_core.sv */
// Top level of the RV32I executor: sequencer, pc, status and result register.
// Steps: write word and read register take their own step before the response step;
// execute: fetch, decode, execute, load for loads; cut short if halted or pc out of range.
// Throughput: one item at a time; the next beat is taken once the result is registered.
// The memory read is registered, which sets the fetch, register read and load steps.
// Reset: pc, status and registers clear at once; data memory then clears one row a
// cycle through all 2^(MEM_ADDR_BITS-2) rows, during which req_ready stays low.
`timescale 1ns / 1ps
module rv32i_instruction_executor_core #(
   parameter int MEM_ADDR_BITS = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  rvx_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output rvx_pkg::rsp_type rsp_data
);
   localparam logic [MEM_ADDR_BITS:0] MEM_SIZE = (MEM_ADDR_BITS+1)'(1) << MEM_ADDR_BITS;

   typedef enum logic [2:0] {
      S_IDLE, S_WR, S_RDREG, S_FETCH, S_DEC, S_EXE, S_LD, S_RESP
   } state_type;

   state_type            state_ff;
   rvx_pkg::req_type     req_ff;
   rvx_pkg::rsp_type     rsp_data_ff;
   logic                 rsp_valid_ff;
   logic [31:0]          pc_ff;
   logic [1:0]           status_ff;
   logic [31:0]          inst_ff;
   logic [31:0]          a0_ff;
   logic                 ld_fit_ff;

   rvx_pkg::mem_ctl_type mem_ctl;
   logic [MEM_ADDR_BITS-1:0] mem_addr;
   logic [31:0]          mem_wdata;
   logic [31:0]          mem_rd_data;
   logic                 mem_busy;

   rvx_pkg::rf_ctl_type  rf_ctl;
   logic [4:0]           rf_addr_a;
   logic [4:0]           rf_waddr;
   logic [31:0]          rf_wdata;
   logic [31:0]          rf_a;
   logic [31:0]          rf_b;

   // decode fields
   logic [6:0]  opc;
   logic [4:0]  rd;
   logic [2:0]  f3;
   logic [6:0]  f7;
   logic [31:0] immi, imms, immb, immj, immu;
   logic [31:0] alu_b, alu_res, ls_addr, wr_addr32, ld_raw, ld_val;
   logic        take, ls_fit, ld_ok, st_ok;
   logic [2:0]  ls_len;
   logic [3:0]  ls_mask;
   logic [31:0] pc_plus4;

   function automatic logic fits_chk(input logic [31:0] addr, input logic [2:0] n);
      logic [MEM_ADDR_BITS:0] sum;
      sum = {1'b0, addr[MEM_ADDR_BITS-1:0]} + (MEM_ADDR_BITS+1)'(n);
      return (addr[31:MEM_ADDR_BITS] == '0) && (sum <= MEM_SIZE);
   endfunction

   assign opc  = inst_ff[6:0];
   assign rd   = inst_ff[11:7];
   assign f3   = inst_ff[14:12];
   assign f7   = inst_ff[31:25];
   assign immi = {{20{inst_ff[31]}}, inst_ff[31:20]};
   assign imms = {{20{inst_ff[31]}}, inst_ff[31:25], inst_ff[11:7]};
   assign immb = {{19{inst_ff[31]}}, inst_ff[31], inst_ff[7], inst_ff[30:25],
                  inst_ff[11:8], 1'b0};
   assign immj = {{11{inst_ff[31]}}, inst_ff[31], inst_ff[19:12], inst_ff[20],
                  inst_ff[30:21], 1'b0};
   assign immu = {inst_ff[31:12], 12'h000};
   assign pc_plus4 = pc_ff + 32'd4;

   // register operand for register ALU ops and branch compares, immediate otherwise
   assign alu_b   = (opc == rvx_pkg::OPC_OP || opc == rvx_pkg::OPC_BRANCH) ? rf_b : immi;
   assign ls_addr = rf_a + ((opc == rvx_pkg::OPC_STORE) ? imms : immi);

   // access length follows funct3 width bits: byte, half, word
   always_comb begin
      case (f3[1:0])
         2'd0:    begin ls_len = 3'd1; ls_mask = 4'b0001; end
         2'd1:    begin ls_len = 3'd2; ls_mask = 4'b0011; end
         default: begin ls_len = 3'd4; ls_mask = 4'b1111; end
      endcase
   end
   assign ls_fit    = fits_chk(ls_addr, ls_len);
   assign st_ok     = (f3 == 3'd0 || f3 == 3'd1 || f3 == 3'd2) && ls_fit;
   assign wr_addr32 = {16'h0, req_ff.word_address, 2'b00};

   rvx_alu u_alu (
      .f3       (f3),
      .f7       (f7),
      .reg_form (opc == rvx_pkg::OPC_OP),
      .a        (rf_a),
      .b        (alu_b),
      .result   (alu_res),
      .take     (take)
   );

   // load result: out-of-range load reads zero
   assign ld_raw = ld_fit_ff ? mem_rd_data : 32'h0;
   always_comb begin
      ld_ok = 1'b1;
      case (f3)
         rvx_pkg::F3_LB:  ld_val = {{24{ld_raw[7]}}, ld_raw[7:0]};
         rvx_pkg::F3_LH:  ld_val = {{16{ld_raw[15]}}, ld_raw[15:0]};
         rvx_pkg::F3_LW:  ld_val = ld_raw;
         rvx_pkg::F3_LBU: ld_val = {24'h0, ld_raw[7:0]};
         rvx_pkg::F3_LHU: ld_val = {16'h0, ld_raw[15:0]};
         default: begin
            ld_val = 32'h0;
            ld_ok  = 1'b0;
         end
      endcase
   end

   // memory port requests
   always_comb begin
      mem_ctl   = '0;
      mem_addr  = ls_addr[MEM_ADDR_BITS-1:0];
      mem_wdata = rf_b;
      case (state_ff)
         S_WR: begin
            mem_ctl.wr_en   = fits_chk(wr_addr32, 3'd4);
            mem_ctl.wr_mask = 4'b1111;
            mem_addr        = wr_addr32[MEM_ADDR_BITS-1:0];
            mem_wdata       = req_ff.write_data;
         end
         S_FETCH: begin
            mem_ctl.rd_en = fits_chk(pc_ff, 3'd4);
            mem_addr      = pc_ff[MEM_ADDR_BITS-1:0];
         end
         S_EXE: begin
            mem_ctl.rd_en   = (opc == rvx_pkg::OPC_LOAD);
            mem_ctl.wr_en   = (opc == rvx_pkg::OPC_STORE) && st_ok;
            mem_ctl.wr_mask = ls_mask;
         end
         default: ;
      endcase
   end

   // register file requests
   always_comb begin
      rf_ctl    = '0;
      rf_addr_a = (state_ff == S_RDREG) ? req_ff.reg_index : mem_rd_data[19:15];
      rf_waddr  = rd;
      rf_wdata  = alu_res;
      case (state_ff)
         S_RDREG: rf_ctl.rd_en = 1'b1;
         S_DEC:   rf_ctl.rd_en = 1'b1;
         S_EXE: begin
            case (opc)
               rvx_pkg::OPC_LUI:   rf_wdata = immu;
               rvx_pkg::OPC_AUIPC: rf_wdata = pc_ff + immu;
               rvx_pkg::OPC_JAL:   rf_wdata = pc_plus4;
               rvx_pkg::OPC_JALR:  rf_wdata = pc_plus4;
               default:            rf_wdata = alu_res;
            endcase
            rf_ctl.wr_en = (rd != 5'd0) &&
                           (opc == rvx_pkg::OPC_LUI || opc == rvx_pkg::OPC_AUIPC ||
                            opc == rvx_pkg::OPC_JAL || opc == rvx_pkg::OPC_JALR ||
                            opc == rvx_pkg::OPC_OPIMM || opc == rvx_pkg::OPC_OP);
         end
         S_LD: begin
            rf_wdata     = ld_val;
            rf_ctl.wr_en = ld_ok && (rd != 5'd0);
         end
         default: ;
      endcase
   end

   rvx_mem #(.ADDR_BITS(MEM_ADDR_BITS)) u_mem (
      .clock   (clock),
      .reset   (reset),
      .ctl     (mem_ctl),
      .addr    (mem_addr),
      .wr_data (mem_wdata),
      .rd_data (mem_rd_data),
      .busy    (mem_busy)
   );

   rvx_regfile u_rf (
      .clock  (clock),
      .reset  (reset),
      .ctl    (rf_ctl),
      .addr_a (rf_addr_a),
      .addr_b (mem_rd_data[24:20]),
      .waddr  (rf_waddr),
      .wdata  (rf_wdata),
      .rd_a   (rf_a),
      .rd_b   (rf_b)
   );

   assign req_ready = (state_ff == S_IDLE) && !mem_busy;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         pc_ff        <= '0;
         status_ff    <= rvx_pkg::ST_RUNNING;
         a0_ff        <= '0;
      end else begin
         // keep the a0 copy in step with the register file
         if (rf_ctl.wr_en && rf_waddr == rvx_pkg::REG_A0) a0_ff <= rf_wdata;
         // drop the result once taken; the response step loads the next one itself
         if (rsp_ready && state_ff != S_RESP) rsp_valid_ff <= 1'b0;

         case (state_ff)
            S_IDLE: begin
               if (req_valid && req_ready) begin
                  req_ff <= req_data;
                  case (req_data.op)
                     rvx_pkg::OP_WRITE_WORD: state_ff <= S_WR;
                     rvx_pkg::OP_READ_REG:   state_ff <= S_RDREG;
                     rvx_pkg::OP_EXECUTE:
                        state_ff <= (status_ff == rvx_pkg::ST_RUNNING) ? S_FETCH : S_RESP;
                     default:                state_ff <= S_RESP;
                  endcase
               end
            end
            S_WR:    state_ff <= S_RESP;
            S_RDREG: state_ff <= S_RESP;
            S_FETCH: begin
               // pc past the last full word: halt without executing
               if (!fits_chk(pc_ff, 3'd4)) begin
                  status_ff <= rvx_pkg::ST_PC_OUT;
                  state_ff  <= S_RESP;
               end else begin
                  state_ff <= S_DEC;
               end
            end
            S_DEC: begin
               inst_ff  <= mem_rd_data;
               state_ff <= S_EXE;
            end
            S_EXE: begin
               ld_fit_ff <= ls_fit;
               state_ff  <= (opc == rvx_pkg::OPC_LOAD) ? S_LD : S_RESP;
               case (opc)
                  rvx_pkg::OPC_JAL:    pc_ff <= pc_ff + immj;
                  rvx_pkg::OPC_JALR:   pc_ff <= (rf_a + immi) & ~32'h1;
                  rvx_pkg::OPC_BRANCH: pc_ff <= take ? pc_ff + immb : pc_plus4;
                  default: begin
                     // ECALL halts and holds pc; everything else advances
                     if (inst_ff == rvx_pkg::INST_ECALL) begin
                        status_ff <= rvx_pkg::ST_ECALL;
                     end else begin
                        pc_ff <= pc_plus4;
                     end
                  end
               endcase
            end
            S_LD: state_ff <= S_RESP;
            S_RESP: begin
               // hold until the result register is free
               if (!rsp_valid_ff || rsp_ready) begin
                  rsp_valid_ff             <= 1'b1;
                  rsp_data_ff.reg_value    <= (req_ff.op == rvx_pkg::OP_READ_REG) ?
                                              rf_a : 32'h0;
                  rsp_data_ff.return_value <= a0_ff;
                  rsp_data_ff.current_pc   <= pc_ff;
                  rsp_data_ff.halt_status  <= status_ff;
                  state_ff                 <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

`ifndef SYNTHESIS
   a_rsp_from_resp: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == S_RESP)
      else $error("result raised outside the response step");

   a_mem_wr_state: assert property (@(posedge clock) disable iff (reset)
      mem_ctl.wr_en |-> (state_ff == S_WR || state_ff == S_EXE))
      else $error("memory write outside a write or execute step");

   a_halt_sticky: assert property (@(posedge clock) disable iff (reset)
      status_ff != rvx_pkg::ST_RUNNING |=> status_ff == $past(status_ff))
      else $error("halt status changed after halting");

   a_no_x0_write: assert property (@(posedge clock) disable iff (reset)
      rf_ctl.wr_en |-> rf_waddr != 5'd0)
      else $error("write to x0");
`endif

endmodule

/* tb/rvx_checker.sv */
// Scoreboard for the RV32I executor: predicts every result beat and compares it.
`timescale 1ns / 1ps
module rvx_checker (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_ready,
   input  rvx_pkg::req_type req_data,
   input  logic             rsp_valid,
   input  logic             rsp_ready,
   input  rvx_pkg::rsp_type rsp_data,
   output int               mismatches,
   output int               outstanding,
   output logic [31:0]      next_pc
);

   localparam int MEM_BYTES = 1 << 16;
   localparam logic [2:0] F3_SB = 3'd0;
   localparam logic [2:0] F3_SH = 3'd1;
   localparam logic [2:0] F3_SW = 3'd2;

   logic [31:0]      gpr [32];
   logic [7:0]       mem [MEM_BYTES];
   logic [31:0]      pc;
   logic [1:0]       status;
   rvx_pkg::rsp_type expected_beats [$];

   function automatic logic [31:0] load_bytes(logic [31:0] addr, int n);
      logic [32:0] last;
      logic [31:0] v;
      last = {1'b0, addr} + 33'(n);
      v = '0;
      if (last > 33'(MEM_BYTES)) return '0;
      for (int i = 0; i < n; i++) v |= 32'(mem[16'(addr + 32'(i))]) << (8 * i);
      return v;
   endfunction

   task automatic store_bytes(logic [31:0] addr, logic [31:0] v, int n);
      logic [32:0] last;
      last = {1'b0, addr} + 33'(n);
      if (last > 33'(MEM_BYTES)) return;
      for (int i = 0; i < n; i++) mem[16'(addr + 32'(i))] = v[8*i +: 8];
   endtask

   task automatic put_reg(logic [4:0] rd, logic [31:0] v);
      if (rd != 5'd0) gpr[rd] = v;
   endtask

   function automatic logic [31:0] alu(logic [2:0] f3, logic [6:0] f7,
                                       logic [31:0] a, logic [31:0] b, bit reg_form);
      case (f3)
         rvx_pkg::F3_ADD:  return (reg_form && f7 != 7'd0) ? a - b : a + b;
         rvx_pkg::F3_SLL:  return a << b[4:0];
         rvx_pkg::F3_SLT:  return ($signed(a) < $signed(b)) ? 32'd1 : 32'd0;
         rvx_pkg::F3_SLTU: return (a < b) ? 32'd1 : 32'd0;
         rvx_pkg::F3_XOR:  return a ^ b;
         rvx_pkg::F3_SR:   return (f7 == 7'd0) ? a >> b[4:0] : 32'($signed(a) >>> b[4:0]);
         rvx_pkg::F3_OR:   return a | b;
         default:          return a & b;
      endcase
   endfunction

   task automatic run_instruction();
      logic [31:0] inst, a, b, immi, imms, immb, immj, addr, nxt, ld;
      logic [6:0]  opc, f7;
      logic [4:0]  rd;
      logic [2:0]  f3;
      bit          take;
      if ({1'b0, pc} + 33'd4 > 33'(MEM_BYTES)) begin
         status = rvx_pkg::ST_PC_OUT;
         return;
      end
      inst = load_bytes(pc, 4);
      opc  = inst[6:0];
      rd   = inst[11:7];
      f3   = inst[14:12];
      f7   = inst[31:25];
      a    = gpr[inst[19:15]];
      b    = gpr[inst[24:20]];
      immi = {{20{inst[31]}}, inst[31:20]};
      imms = {{20{inst[31]}}, inst[31:25], inst[11:7]};
      immb = {{19{inst[31]}}, inst[31], inst[7], inst[30:25], inst[11:8], 1'b0};
      immj = {{11{inst[31]}}, inst[31], inst[19:12], inst[20], inst[30:21], 1'b0};
      nxt  = pc + 32'd4;
      take = 1'b0;
      case (opc)
         rvx_pkg::OPC_LUI:   put_reg(rd, {inst[31:12], 12'd0});
         rvx_pkg::OPC_AUIPC: put_reg(rd, pc + {inst[31:12], 12'd0});
         rvx_pkg::OPC_JAL: begin
            put_reg(rd, pc + 32'd4);
            nxt = pc + immj;
         end
         rvx_pkg::OPC_JALR: begin
            nxt = (a + immi) & ~32'd1;
            put_reg(rd, pc + 32'd4);
         end
         rvx_pkg::OPC_BRANCH: begin
            case (f3)
               rvx_pkg::F3_BEQ:  take = (a == b);
               rvx_pkg::F3_BNE:  take = (a != b);
               rvx_pkg::F3_BLT:  take = ($signed(a) < $signed(b));
               rvx_pkg::F3_BGE:  take = ($signed(a) >= $signed(b));
               rvx_pkg::F3_BLTU: take = (a < b);
               rvx_pkg::F3_BGEU: take = (a >= b);
               default:          take = 1'b0;
            endcase
            if (take) nxt = pc + immb;
         end
         rvx_pkg::OPC_LOAD: begin
            addr = a + immi;
            case (f3)
               rvx_pkg::F3_LB: begin
                  ld = load_bytes(addr, 1);
                  put_reg(rd, {{24{ld[7]}}, ld[7:0]});
               end
               rvx_pkg::F3_LH: begin
                  ld = load_bytes(addr, 2);
                  put_reg(rd, {{16{ld[15]}}, ld[15:0]});
               end
               rvx_pkg::F3_LW:  put_reg(rd, load_bytes(addr, 4));
               rvx_pkg::F3_LBU: put_reg(rd, load_bytes(addr, 1));
               rvx_pkg::F3_LHU: put_reg(rd, load_bytes(addr, 2));
               default: ;
            endcase
         end
         rvx_pkg::OPC_STORE: begin
            addr = a + imms;
            case (f3)
               F3_SB:   store_bytes(addr, b, 1);
               F3_SH:   store_bytes(addr, b, 2);
               F3_SW:   store_bytes(addr, b, 4);
               default: ;
            endcase
         end
         rvx_pkg::OPC_OPIMM: put_reg(rd, alu(f3, f7, a, immi, 1'b0));
         rvx_pkg::OPC_OP:    put_reg(rd, alu(f3, f7, a, b, 1'b1));
         default: begin
            if (inst == rvx_pkg::INST_ECALL) begin
               status = rvx_pkg::ST_ECALL;
               nxt = pc;
            end
         end
      endcase
      pc = nxt;
   endtask

   always @(posedge clock) begin
      rvx_pkg::rsp_type e;
      logic [31:0] rv;
      if (reset) begin
         foreach (gpr[i]) gpr[i] = '0;
         foreach (mem[i]) mem[i] = '0;
         pc = '0;
         status = rvx_pkg::ST_RUNNING;
         expected_beats.delete();
         mismatches = 0;
      end else begin
         // retire first: a result beat always belongs to an earlier request
         if (rsp_valid && rsp_ready) begin
            if (expected_beats.size() == 0) begin
               $display("%0t: result beat with nothing expected, got %p", $time, rsp_data);
               mismatches++;
            end else begin
               e = expected_beats.pop_front();
               if (rsp_data.reg_value !== e.reg_value) begin
                  $display("%0t: reg_value expected %h got %h", $time, e.reg_value,
                           rsp_data.reg_value);
                  mismatches++;
               end
               if (rsp_data.return_value !== e.return_value) begin
                  $display("%0t: return_value expected %h got %h", $time, e.return_value,
                           rsp_data.return_value);
                  mismatches++;
               end
               if (rsp_data.current_pc !== e.current_pc) begin
                  $display("%0t: current_pc expected %h got %h", $time, e.current_pc,
                           rsp_data.current_pc);
                  mismatches++;
               end
               if (rsp_data.halt_status !== e.halt_status) begin
                  $display("%0t: halt_status expected %0d got %0d", $time, e.halt_status,
                           rsp_data.halt_status);
                  mismatches++;
               end
            end
         end
         if (req_valid && req_ready) begin
            rv = '0;
            case (req_data.op)
               rvx_pkg::OP_WRITE_WORD: store_bytes({16'd0, req_data.word_address, 2'b00},
                                                   req_data.write_data, 4);
               rvx_pkg::OP_EXECUTE:    if (status == rvx_pkg::ST_RUNNING) run_instruction();
               rvx_pkg::OP_READ_REG:   rv = gpr[req_data.reg_index];
               default: ;
            endcase
            e.reg_value    = rv;
            e.return_value = gpr[rvx_pkg::REG_A0];
            e.current_pc   = pc;
            e.halt_status  = status;
            expected_beats = {expected_beats, e};
         end
      end
      outstanding = expected_beats.size();
      next_pc = pc;
   end

endmodule

/* tb/testbench.sv */
// Top of the RV32I executor bench: clock, reset, stimulus, back-pressure and verdict.
`timescale 1ns / 1ps
module testbench;

   // op code outside the defined set; the block must just report its state
   localparam logic [1:0] OP_SPARE = 2'd3;
   // no handshake for this long means the block is stuck (covers the memory clear)
   localparam int IDLE_LIMIT = 60000;
   localparam int RANDOM_BEATS = 1400;
   localparam int CODE_TOP = 32'hF000;

   logic             clock;
   logic             reset;
   logic             req_valid;
   logic             req_ready;
   rvx_pkg::req_type req_data;
   logic             rsp_valid;
   logic             rsp_ready;
   rvx_pkg::rsp_type rsp_data;

   int          mismatches;
   int          outstanding;
   logic [31:0] next_pc;

   int beats_sent;
   int executes;
   int reg_reads;
   int burst_left;
   int idle_cycles;
   bit long_hold_due;
   bit long_hold_done;

   rv32i_instruction_executor_core dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   rvx_checker scoreboard (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data),
      .mismatches  (mismatches),
      .outstanding (outstanding),
      .next_pc     (next_pc)
   );

   always begin
      clock = 1'b1;
      #6;
      clock = 1'b0;
      #6;
   end

   // Instruction encoders
   function automatic logic [31:0] enc_i(logic [6:0] opc, logic [4:0] rd, logic [2:0] f3,
                                         logic [4:0] rs1, logic [11:0] imm);
      return {imm, rs1, f3, rd, opc};
   endfunction

   function automatic logic [31:0] enc_r(logic [6:0] f7, logic [4:0] rs2, logic [4:0] rs1,
                                         logic [2:0] f3, logic [4:0] rd);
      return {f7, rs2, rs1, f3, rd, rvx_pkg::OPC_OP};
   endfunction

   function automatic logic [31:0] enc_s(logic [2:0] f3, logic [4:0] rs1, logic [4:0] rs2,
                                         logic [11:0] imm);
      return {imm[11:5], rs2, rs1, f3, imm[4:0], rvx_pkg::OPC_STORE};
   endfunction

   function automatic logic [31:0] enc_b(logic [2:0] f3, logic [4:0] rs1, logic [4:0] rs2,
                                         logic [12:0] off);
      return {off[12], off[10:5], rs2, rs1, f3, off[4:1], off[11], rvx_pkg::OPC_BRANCH};
   endfunction

   function automatic logic [31:0] enc_j(logic [4:0] rd, logic [20:0] off);
      return {off[20], off[10:1], off[11], off[19:12], rd, rvx_pkg::OPC_JAL};
   endfunction

   // Random instruction whose control flow stays inside the code area, so the
   // core only halts when the run decides to halt it.
   function automatic logic [31:0] random_instruction(logic [31:0] pc);
      logic [31:0] w, tgt;
      logic [4:0]  rd, rs1, rs2;
      logic [6:0]  f7;
      int          off;
      rd  = 5'($urandom);
      rs1 = 5'($urandom);
      rs2 = 5'($urandom);
      case ($urandom_range(0, 10))
         0: w = {20'($urandom), rd, rvx_pkg::OPC_LUI};
         1: w = {20'($urandom), rd, rvx_pkg::OPC_AUIPC};
         2, 3: w = enc_i(rvx_pkg::OPC_OPIMM, rd, 3'($urandom), rs1, 12'($urandom));
         4: begin
            case ($urandom_range(0, 2))
               0: f7 = 7'h00;
               1: f7 = 7'h20;
               default: f7 = 7'($urandom);
            endcase
            w = enc_r(f7, rs2, rs1, 3'($urandom), rd);
         end
         5: begin
            // half the loads go through x0 so they hit written memory
            if ($urandom_range(0, 1)) rs1 = 5'd0;
            w = enc_i(rvx_pkg::OPC_LOAD, rd, 3'($urandom), rs1, 12'($urandom));
         end
         6: begin
            if ($urandom_range(0, 1)) rs1 = 5'd0;
            w = enc_s(3'($urandom_range(0, 3)), rs1, rs2, 12'($urandom));
         end
         7: begin
            off = (int'($urandom_range(0, 2000)) - 1000) * 4;
            tgt = pc + 32'(off);
            if (int'(pc) + off < 0 || tgt > CODE_TOP) off = 8;
            w = enc_b(3'($urandom), rs1, rs2, 13'(off));
         end
         8: begin
            tgt = 32'($urandom_range(0, CODE_TOP / 4)) * 4;
            w = enc_j(rd, 21'(tgt - pc));
         end
         9: w = enc_i(rvx_pkg::OPC_JALR, rd, 3'd0, 5'd0, 12'($urandom_range(0, 511) * 4));
         default: begin
            w = $urandom;
            // keep noise away from control flow and the halting word
            if (w[6:0] == rvx_pkg::OPC_JAL || w[6:0] == rvx_pkg::OPC_JALR ||
                w[6:0] == rvx_pkg::OPC_BRANCH || w == rvx_pkg::INST_ECALL)
               w[6:0] = 7'h0B;
         end
      endcase
      return w;
   endfunction

   // Offer one beat; returns at the falling edge after it was taken, so that the
   // scoreboard has settled before the caller looks at the predicted pc.
   task automatic send_beat(logic [1:0] op, logic [13:0] waddr, logic [31:0] wdata,
                            logic [4:0] ridx);
      rvx_pkg::req_type r;
      r.op = op;
      r.word_address = waddr;
      r.write_data = wdata;
      r.reg_index = ridx;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 30);
         repeat ($urandom_range(0, 12)) @(posedge clock);
      end
      burst_left--;
      @(posedge clock);
      req_valid <= 1'b1;
      req_data  <= r;
      do @(posedge clock); while (!(req_valid && req_ready));
      req_valid <= 1'b0;
      beats_sent++;
      if (op == rvx_pkg::OP_EXECUTE) executes++;
      if (op == rvx_pkg::OP_READ_REG) reg_reads++;
      @(negedge clock);
   endtask

   // Place an instruction at the predicted pc and step over it
   task automatic execute_word(logic [31:0] inst);
      send_beat(rvx_pkg::OP_WRITE_WORD, next_pc[15:2], inst, 5'($urandom));
      send_beat(rvx_pkg::OP_EXECUTE, 14'($urandom), 32'($urandom), 5'($urandom));
   endtask

   // Receiver back-pressure: segments of steady, patchy and mostly-stalled
   // readiness, with one long hold-off part way through the run.
   initial begin
      int seg;
      int mode;
      forever begin
         seg  = $urandom_range(20, 200);
         mode = $urandom_range(0, 2);
         repeat (seg) begin
            @(posedge clock);
            case (mode)
               0: rsp_ready <= 1'b1;
               1: rsp_ready <= 1'($urandom_range(0, 1));
               default: rsp_ready <= ($urandom_range(0, 3) == 0);
            endcase
         end
         if (long_hold_due && !long_hold_done) begin
            @(posedge clock);
            rsp_ready <= 1'b0;
            repeat (400) @(posedge clock);
            long_hold_done = 1'b1;
         end
      end
   end

   // Watchdog: any beat on either channel counts as progress
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles == IDLE_LIMIT) begin
            $display("%0t: no handshake for %0d cycles", $time, IDLE_LIMIT);
            $display("simulation failed");
            $finish;
         end
      end
   end

   initial begin
      int pick;
      req_valid = 1'b0;
      req_data  = '0;
      rsp_ready = 1'b0;
      reset     = 1'b1;
      beats_sent = 0;
      executes = 0;
      reg_reads = 0;
      burst_left = 0;
      idle_cycles = 0;
      long_hold_due = 1'b0;
      long_hold_done = 1'b0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed: field extremes, the spare op, then a short program that hits
      // sign edges, unaligned and out-of-range accesses and a discarded link.
      send_beat(rvx_pkg::OP_READ_REG, 14'd0, 32'd0, 5'd0);
      send_beat(OP_SPARE, 14'h3FFF, 32'hFFFF_FFFF, 5'd31);
      send_beat(rvx_pkg::OP_WRITE_WORD, 14'h3FFF, 32'hFFFF_FFFF, 5'd31);
      // a0 = min int
      execute_word({20'h80000, rvx_pkg::REG_A0, rvx_pkg::OPC_LUI});
      // x11 = -1
      execute_word(enc_i(rvx_pkg::OPC_OPIMM, 5'd11, rvx_pkg::F3_ADD, 5'd0, 12'hFFF));
      // unaligned word
      execute_word(enc_s(3'd2, 5'd0, 5'd11, 12'h101));
      // sign-extended half
      execute_word(enc_i(rvx_pkg::OPC_LOAD, 5'd12, rvx_pkg::F3_LH, 5'd0, 12'h102));
      // past the end: zero
      execute_word(enc_i(rvx_pkg::OPC_LOAD, 5'd13, rvx_pkg::F3_LW, 5'd0, 12'hFFF));
      // store dropped
      execute_word(enc_s(3'd2, rvx_pkg::REG_A0, 5'd11, 12'h000));
      // min - (-1)
      execute_word(enc_r(7'h20, 5'd11, rvx_pkg::REG_A0, rvx_pkg::F3_ADD, 5'd14));
      // arith shift by 31
      execute_word(enc_i(rvx_pkg::OPC_OPIMM, 5'd15, rvx_pkg::F3_SR, 5'd11, 12'h41F));
      // link to x0 dropped
      execute_word(enc_j(5'd0, 21'd8));
      send_beat(rvx_pkg::OP_READ_REG, 14'd0, 32'd0, 5'd12);

      // Random programs with register reads, stray writes and spare ops mixed in
      while (beats_sent < RANDOM_BEATS) begin
         if (beats_sent > RANDOM_BEATS / 2) long_hold_due = 1'b1;
         pick = $urandom_range(0, 99);
         if (pick < 72) execute_word(random_instruction(next_pc));
         else if (pick < 84)
            send_beat(rvx_pkg::OP_READ_REG, 14'($urandom), $urandom, 5'($urandom));
         else if (pick < 94)
            send_beat(rvx_pkg::OP_WRITE_WORD, 14'($urandom), $urandom, 5'($urandom));
         else send_beat(OP_SPARE, 14'($urandom), $urandom, 5'($urandom));
      end

      // Halt the core one way or the other, then step while halted
      if ($urandom_range(0, 1)) execute_word(rvx_pkg::INST_ECALL);
      else begin
         execute_word(enc_i(rvx_pkg::OPC_JALR, 5'd1, 3'd0, 5'd0, 12'hFFC));
         send_beat(rvx_pkg::OP_EXECUTE, 14'd0, 32'd0, 5'd0);
      end
      send_beat(rvx_pkg::OP_EXECUTE, 14'd0, 32'd0, 5'd0);
      send_beat(rvx_pkg::OP_READ_REG, 14'd0, 32'd0, rvx_pkg::REG_A0);

      while (outstanding != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      $display("covered %0d request beats: %0d instruction steps, %0d register reads,",
               beats_sent, executes, reg_reads);
      $display("with one long result stall and a final halt");
      if (mismatches == 0) $display("simulation ok");
      else $display("simulation failed");
      $finish;
   end

endmodule
